// ----- hdl/irpr_pkg.sv -----
// ----------------------------------------------------------------------------
// irpr_pkg
// Shared types and constants of the integer ratio PCM resampler.
// ----------------------------------------------------------------------------
package irpr_pkg;

    localparam int MAX_RATIO = 8;
    localparam int SMP_W     = 16;
    localparam int NUM_W     = 20;
    localparam int RAT_W     = 4;
    localparam int CFG_W     = 4;

    localparam logic CFG_RATIO = 1'b0;
    localparam logic CFG_MODE  = 1'b1;

    localparam logic [RAT_W-1:0] RATIO_RST = RAT_W'(2);
    localparam logic [RAT_W-1:0] RATIO_MAX = RAT_W'(MAX_RATIO);

    typedef logic signed [SMP_W-1:0] t_smp;
    typedef logic signed [NUM_W-1:0] t_num;
    typedef logic [RAT_W-1:0]        t_rat;

    typedef struct packed {
        logic start;
        t_num numer;
        t_rat dvsr;
    } t_div_req;

    typedef struct packed {
        logic done;
        t_smp quot;
    } t_div_rsp;

endpackage

// ----- hdl/irpr_in_if.sv -----
// ----------------------------------------------------------------------------
// irpr_in_if
// Input item channel: one PCM sample and its block end flag.
// ----------------------------------------------------------------------------
interface irpr_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               block_end;

    modport source (output valid, output sample, output block_end, input ready);
    modport sink   (input valid, input sample, input block_end, output ready);
endinterface

// ----- hdl/irpr_out_if.sv -----
// ----------------------------------------------------------------------------
// irpr_out_if
// Result item channel: one resampled PCM sample and its last flag.
// ----------------------------------------------------------------------------
interface irpr_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_sample;
    logic               run_last;

    modport source (output valid, output out_sample, output run_last, input ready);
    modport sink   (input valid, input out_sample, input run_last, output ready);
endinterface

// ----- hdl/irpr_div.sv -----
// ----------------------------------------------------------------------------
// irpr_div
// Iterative signed divider, four quotient bits per cycle, truncates toward
// zero. Divisor range 1..8, quotient taken to 16 bits.
// ----------------------------------------------------------------------------
module irpr_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  irpr_pkg::t_div_req i_req,
    output irpr_pkg::t_div_rsp o_rsp
);
    import irpr_pkg::*;

    localparam int STEPS  = 4;
    localparam int ROUNDS = NUM_W / STEPS;
    localparam int CNT_W  = $clog2(ROUNDS);
    localparam int REM_W  = RAT_W + 1;

    logic [NUM_W-1:0] r_mag, n_mag;
    logic [REM_W-1:0] r_rem, n_rem;
    logic [CNT_W-1:0] r_cnt;
    t_rat             r_dvsr;
    logic             r_neg;
    logic             r_busy;
    logic             r_done;
    logic [NUM_W-1:0] w_quot;

    always_comb begin
        n_mag = r_mag;
        n_rem = r_rem;
        for (int i = 0; i < STEPS; i++) begin
            n_rem = {n_rem[REM_W-2:0], n_mag[NUM_W-1]};
            n_mag = {n_mag[NUM_W-2:0], 1'b0};
            if (n_rem >= {1'b0, r_dvsr}) begin
                n_rem    = n_rem - {1'b0, r_dvsr};
                n_mag[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(ROUNDS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mag  <= i_req.numer[NUM_W-1] ? NUM_W'(-i_req.numer) : NUM_W'(i_req.numer);
            r_neg  <= i_req.numer[NUM_W-1];
            r_rem  <= '0;
            r_dvsr <= i_req.dvsr;
        end else if (r_busy) begin
            r_mag <= n_mag;
            r_rem <= n_rem;
        end
    end

    assign w_quot     = r_neg ? (~r_mag + NUM_W'(1)) : r_mag;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = w_quot[SMP_W-1:0];

endmodule

// ----- hdl/integer_ratio_pcm_resampler_unit.sv -----
// ----------------------------------------------------------------------------
// integer_ratio_pcm_resampler_unit
// Resamples signed 16-bit PCM by an integer ratio N, interpolating up or
// averaging down, with one shared iterative divider under a small sequencer.
// ----------------------------------------------------------------------------
// The block takes one input item at a time and is not ready until every
// result of that item has gone into the output register. Each result that
// needs a division passes through these steps in order: start the divider,
// let it run over the 20-bit numerator at four quotient bits a cycle, take
// the quotient and load the output register. An up mode item with a
// previous sample needs N divisions, and a block end adds N repeats of the
// sample; a down mode item needs a division only when it closes a group.
// A stalled output holds the block. Ratio 0 acts as 1 and ratios above
// eight act as eight.
// ----------------------------------------------------------------------------
module integer_ratio_pcm_resampler_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [irpr_pkg::CFG_W-1:0] i_cfg_data,
    irpr_in_if.sink                    i_in,
    irpr_out_if.source                 o_out
);
    import irpr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_EMIT = 4'b0100,
        S_REP  = 4'b1000
    } t_state;

    t_state           r_state;
    t_rat             r_ratio;
    logic             r_up_mode;
    t_smp             r_prev;
    logic             r_have_prev;
    t_num             r_gsum;
    t_rat             r_gcnt;

    t_rat             r_n;
    t_rat             r_c;
    t_rat             r_dvsr;
    t_num             r_num;
    logic signed [SMP_W:0] r_delta;
    t_smp             r_x1;
    t_smp             r_q;
    logic             r_rep;
    logic             r_dstart;

    logic             r_ovalid;
    t_smp             r_osample;
    logic             r_olast;

    t_rat             w_n;
    t_num             w_sum;
    t_rat             w_cnt;
    logic             w_accept;
    logic             w_free;
    logic             w_final;
    logic             w_dstart;
    logic             w_load;
    t_div_req         w_req;
    t_div_rsp         w_rsp;

    assign w_n = (r_ratio == '0) ? RAT_W'(1) :
                 (r_ratio > RATIO_MAX) ? RATIO_MAX : r_ratio;
    assign w_sum    = r_gsum + NUM_W'(i_in.sample);
    assign w_cnt    = r_gcnt + RAT_W'(1);
    assign w_accept = i_in.valid && (r_state == S_IDLE);
    assign w_free   = !r_ovalid || o_out.ready;
    assign w_final  = (r_c == r_n - RAT_W'(1));
    assign w_dstart = (w_accept && (r_up_mode ? r_have_prev : (w_cnt >= w_n))) ||
                      ((r_state == S_EMIT) && w_free && !w_final);
    assign w_load   = ((r_state == S_EMIT) || (r_state == S_REP)) && w_free;

    assign i_in.ready = (r_state == S_IDLE);

    assign w_req.start = r_dstart;
    assign w_req.numer = r_num;
    assign w_req.dvsr  = r_dvsr;

    irpr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio   <= RATIO_RST;
            r_up_mode <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RATIO: r_ratio   <= i_cfg_data[RAT_W-1:0];
                CFG_MODE:  r_up_mode <= i_cfg_data[0];
                default:   r_ratio   <= r_ratio;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev      <= '0;
            r_have_prev <= 1'b0;
            r_gsum      <= '0;
            r_gcnt      <= '0;
            r_dstart    <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_dstart <= w_dstart;
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_n  <= w_n;
                        r_x1 <= i_in.sample;
                        if (r_up_mode) begin
                            r_rep       <= i_in.block_end;
                            r_c         <= '0;
                            r_prev      <= i_in.sample;
                            r_have_prev <= !i_in.block_end;
                            r_num       <= NUM_W'(r_prev) * NUM_W'(w_n);
                            r_delta     <= (SMP_W+1)'(i_in.sample) - (SMP_W+1)'(r_prev);
                            r_dvsr      <= w_n;
                            if (r_have_prev) begin
                                r_state <= S_DIV;
                            end else if (i_in.block_end) begin
                                r_state <= S_REP;
                            end
                        end else begin
                            r_num  <= w_sum;
                            r_dvsr <= w_cnt;
                            r_rep  <= 1'b0;
                            r_c    <= w_n - RAT_W'(1);
                            if (w_cnt >= w_n || i_in.block_end) begin
                                r_gsum <= '0;
                                r_gcnt <= '0;
                            end else begin
                                r_gsum <= w_sum;
                                r_gcnt <= w_cnt;
                            end
                            if (w_cnt >= w_n) begin
                                r_state <= S_DIV;
                            end
                        end
                    end
                end
                S_DIV: begin
                    if (w_rsp.done) begin
                        r_q     <= w_rsp.quot;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_free) begin
                        r_osample <= r_q;
                        r_olast   <= w_final && !r_rep;
                        if (w_final) begin
                            r_c     <= '0;
                            r_state <= r_rep ? S_REP : S_IDLE;
                        end else begin
                            r_c     <= r_c + RAT_W'(1);
                            r_num   <= r_num + NUM_W'(r_delta);
                            r_state <= S_DIV;
                        end
                    end
                end
                S_REP: begin
                    if (w_free) begin
                        r_osample <= r_x1;
                        r_olast   <= w_final;
                        if (w_final) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_c <= r_c + RAT_W'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.out_sample = r_osample;
    assign o_out.run_last   = r_olast;

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the integer ratio PCM resampler. A scoreboard class
// predicts every output sample from the accepted input items and the current
// ratio and mode, then checks outputs in order. Directed items cover extremes,
// block ends, mode changes and ratio changes in the middle of a group. Random
// phases follow with varied ratios, idle patterns and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import irpr_pkg::*;

    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 48;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        t_smp smp;
        logic run_last;
    } t_pcm_result;

    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idling;

    class resample_scoreboard;
        t_rat              ratio_r;
        logic              up_mode;
        t_smp              prev_smp;
        bit                have_prev;
        t_num              grp_sum;
        logic [RAT_W-1:0]  grp_cnt;
        t_pcm_result       owed[$];
        int                errors;

        function new();
            ratio_r   = RATIO_RST;
            up_mode   = 1'b1;
            prev_smp  = '0;
            have_prev = 1'b0;
            grp_sum   = '0;
            grp_cnt   = '0;
            errors    = 0;
        endfunction

        function void write_reg(logic idx, logic [CFG_W-1:0] data);
            if (idx == CFG_RATIO) begin
                ratio_r = t_rat'(data);
            end else begin
                up_mode = data[0];
            end
        endfunction

        function void push_result(t_smp s);
            t_pcm_result r;
            r.smp      = s;
            r.run_last = 1'b0;
            owed.push_back(r);
        endfunction

        function void note_sample(t_smp x, logic blk_end);
            int n;
            int base;
            int cnt;
            int num;
            base = owed.size();
            if (ratio_r == '0) begin
                n = 1;
            end else if (ratio_r > RATIO_MAX) begin
                n = MAX_RATIO;
            end else begin
                n = int'(ratio_r);
            end
            if (up_mode) begin
                if (have_prev) begin
                    for (int c = 0; c < n; c++) begin
                        num = int'(prev_smp) * (n - c) + int'(x) * c;
                        push_result(t_smp'(num / n));
                    end
                end
                prev_smp  = x;
                have_prev = 1'b1;
                if (blk_end) begin
                    for (int c = 0; c < n; c++) push_result(x);
                    have_prev = 1'b0;
                end
            end else begin
                grp_sum = t_num'(int'(grp_sum) + int'(x));
                grp_cnt = grp_cnt + 1'b1;
                cnt     = int'(grp_cnt);
                if (cnt >= n) begin
                    push_result(t_smp'(int'(grp_sum) / cnt));
                    grp_sum = '0;
                    grp_cnt = '0;
                end
                if (blk_end) begin
                    grp_sum = '0;
                    grp_cnt = '0;
                end
            end
            if (owed.size() > base) owed[owed.size() - 1].run_last = 1'b1;
        endfunction

        function void check_result(t_smp s, logic rl);
            t_pcm_result e;
            if (owed.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("%0t: unexpected result %0d last %0b", $time, s, rl);
                return;
            end
            e = owed.pop_front();
            if (e.smp !== s || e.run_last !== rl) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("%0t: result mismatch: expected %0d last %0b, got %0d last %0b",
                             $time, e.smp, e.run_last, s, rl);
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    logic             cfg_idx;
    logic [CFG_W-1:0] cfg_data;

    int send_idle_pct;
    int recv_stall_pct;
    bit hold_req;
    int hold_left;

    resample_scoreboard sb = new();

    irpr_in_if  in_ch();
    irpr_out_if out_ch();

    integer_ratio_pcm_resampler_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("** integer_ratio_pcm_resampler_unit: FAILED **");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready)
            sb.note_sample(in_ch.sample, in_ch.block_end);
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.out_sample, out_ch.run_last);
    end

    // hold the output off for a long stretch on request, else stall at random
    initial begin
        out_ch.ready = 1'b0;
        hold_left    = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic void set_idling(t_idling idl);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        case (idl)
            IDLE_SEND: send_idle_pct = 79;
            IDLE_RECV: recv_stall_pct = 79;
            IDLE_BOTH: begin
                send_idle_pct  = 9;
                recv_stall_pct = 9;
            end
            default: ;
        endcase
    endfunction

    function automatic t_smp rand_sample();
        case ($urandom_range(7))
            0: return t_smp'(16'h8000);
            1: return t_smp'(16'h7fff);
            2: return t_smp'(int'($urandom_range(32)) - 16);
            default: return t_smp'($urandom);
        endcase
    endfunction

    task automatic send_item(input t_smp s, input logic be);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.sample    <= s;
        in_ch.block_end <= be;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input t_rat r, input logic up);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_RATIO;
        cfg_data <= CFG_W'(r);
        sb.write_reg(CFG_RATIO, CFG_W'(r));
        @(posedge i_clk);
        cfg_idx  <= CFG_MODE;
        cfg_data <= CFG_W'(up);
        sb.write_reg(CFG_MODE, CFG_W'(up));
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_phase(input t_rat r, input logic up, input t_idling idl,
                             input bit pressure);
        int sent;
        int len;
        settle();
        configure(r, up);
        set_idling(idl);
        if (pressure) hold_req = 1'b1;
        sent = 0;
        while (sent < PHASE_ITEMS) begin
            if ($urandom_range(7) == 0) begin
                send_item(rand_sample(), 1'($urandom_range(1)));
                sent++;
            end else begin
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++) send_item(rand_sample(), i == len - 1);
                sent += len;
            end
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = CFG_RATIO;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.sample    = '0;
        in_ch.block_end = 1'b0;
        hold_req        = 1'b0;
        set_idling(IDLE_NONE);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: interpolate by two
        send_item(t_smp'(16'h7fff), 1'b0);
        send_item(t_smp'(16'h8000), 1'b0);
        send_item(t_smp'(0), 1'b1);
        send_item(t_smp'(16'h8000), 1'b1);

        settle();
        configure(t_rat'(8), 1'b1);
        send_item(t_smp'(16'h8000), 1'b0);
        send_item(t_smp'(16'h7fff), 1'b0);
        send_item(t_smp'(-1), 1'b1);

        // open a group of eight, then lower the ratio so it closes at six
        settle();
        configure(t_rat'(8), 1'b0);
        repeat (5) send_item(t_smp'(16'h7fff), 1'b0);
        settle();
        configure(t_rat'(3), 1'b0);
        send_item(t_smp'(16'h7fff), 1'b0);
        send_item(t_smp'(16'h8000), 1'b0);
        send_item(t_smp'(16'h8000), 1'b1);

        settle();
        configure(t_rat'(1), 1'b0);
        send_item(t_smp'(16'h8000), 1'b0);
        send_item(t_smp'(16'h7fff), 1'b1);

        // leave a held sample in up mode across a mode change
        settle();
        configure(t_rat'(0), 1'b1);
        send_item(t_smp'(1000), 1'b0);
        settle();
        configure(t_rat'(0), 1'b0);
        send_item(t_smp'(-5), 1'b0);
        settle();
        configure(t_rat'(15), 1'b1);
        send_item(t_smp'(16'h8000), 1'b1);

        run_phase(t_rat'(8), 1'b1, IDLE_NONE, 1'b1);
        run_phase(t_rat'(1), 1'b0, IDLE_SEND, 1'b0);
        run_phase(t_rat'(0), 1'b1, IDLE_RECV, 1'b0);
        run_phase(t_rat'(15), 1'b0, IDLE_BOTH, 1'b0);
        run_phase(t_rat'(8), 1'b0, IDLE_NONE, 1'b0);
        run_phase(t_rat'(9), 1'b1, IDLE_SEND, 1'b0);
        run_phase(t_rat'($urandom_range(1, 8)), 1'b1, IDLE_RECV, 1'b0);
        run_phase(t_rat'($urandom_range(1, 8)), 1'b0, IDLE_BOTH, 1'b0);

        settle();
        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("** integer_ratio_pcm_resampler_unit: PASSED **");
        end else begin
            $display("** integer_ratio_pcm_resampler_unit: FAILED **");
        end
        $finish;
    end

endmodule
